// ===== sv/pcpa_pkg.sv =====
package pcpa_pkg;

   // Field widths of the item and result.
   localparam int POS_W     = 24;
   localparam int DIFF_W    = 25;
   localparam int DIST_W    = 25;
   localparam int SLOT_IN_W = 6;
   localparam int CSR_IDX_W = 2;

   // Distance unit: squares, radicand and the digit-by-digit root.
   localparam int SQ_W       = 48;
   localparam int RAD_W      = 50;
   localparam int REM_W      = 26;
   localparam int ROOT_STEPS = RAD_W / 2;
   localparam int STEP_W     = $clog2(ROOT_STEPS);

   // Register indexes of the configuration port.
   localparam logic [CSR_IDX_W-1:0] CSR_IGNORE = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_REPORT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_SWING  = 2'd2;

   // Register values after reset.
   localparam logic [DIST_W-1:0] IGNORE_RESET = 25'd1600;
   localparam logic [DIST_W-1:0] REPORT_RESET = 25'd800;
   localparam logic [DIST_W-1:0] SWING_RESET  = 25'd16;

   // Range history of one pair, as held in the pair table.
   typedef struct packed {
      logic [DIST_W-1:0] last;
      logic [DIST_W-1:0] run_min;
      logic [DIST_W-1:0] run_max;
      logic              has_dist;
      logic              closing;
      logic              valid;
   } slot_type;

   // Per-item part of a result.
   typedef struct packed {
      logic              cpa_event;
      logic [DIST_W-1:0] cpa_distance;
      logic [POS_W-1:0]  mid_x;
      logic [POS_W-1:0]  mid_y;
      logic [DIST_W-1:0] distance;
      logic              skipped;
   } rsp_type;

endpackage

// ===== sv/pcpa_ram.sv =====
module pcpa_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== sv/pcpa_dist.sv =====
module pcpa_dist
   import pcpa_pkg::*;
(
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     start,
   input  logic signed [DIFF_W-1:0] dx,
   input  logic signed [DIFF_W-1:0] dy,
   output logic                     done,
   output logic [DIST_W-1:0]        distance
);

   localparam logic [2:0] P_IDLE = 3'd0;
   localparam logic [2:0] P_SQX  = 3'd1;
   localparam logic [2:0] P_SQY  = 3'd2;
   localparam logic [2:0] P_SUM  = 3'd3;
   localparam logic [2:0] P_ROOT = 3'd4;

   logic [2:0]               phase_ff, phase_in;
   logic [STEP_W-1:0]        step_ff, step_in;
   logic                     done_ff, done_in;
   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [SQ_W-1:0]          prod_ff, prod_in;
   logic [RAD_W-1:0]         rad_ff, rad_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [DIST_W-1:0]        root_ff, root_in;

   logic signed [DIFF_W-1:0]   mul_op;
   logic signed [2*DIFF_W-1:0] sq_full;
   logic [REM_W+1:0]           rem_shift, trial, rem_diff;
   logic                       take;

   // One shared multiplier squares dx, then dy.
   assign mul_op  = (phase_ff == P_SQX) ? dx_ff : dy_ff;
   assign sq_full = mul_op * mul_op;

   // One root digit a step: bring down two radicand bits, try 4*root+1.
   assign rem_shift = {rem_ff, rad_ff[RAD_W-1 -: 2]};
   assign trial     = {1'b0, root_ff, 2'b01};
   assign take      = rem_shift >= trial;
   assign rem_diff  = rem_shift - trial;

   always_comb begin
      phase_in = phase_ff;
      step_in  = step_ff;
      done_in  = 1'b0;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      prod_in  = prod_ff;
      rad_in   = rad_ff;
      rem_in   = rem_ff;
      root_in  = root_ff;
      unique case (phase_ff)
         P_IDLE: begin
            if (start) begin
               dx_in    = dx;
               dy_in    = dy;
               phase_in = P_SQX;
            end
         end
         P_SQX: begin
            prod_in  = sq_full[SQ_W-1:0];
            phase_in = P_SQY;
         end
         P_SQY: begin
            rad_in   = {2'b00, prod_ff};
            prod_in  = sq_full[SQ_W-1:0];
            phase_in = P_SUM;
         end
         P_SUM: begin
            rad_in   = rad_ff + {2'b00, prod_ff};
            rem_in   = '0;
            root_in  = '0;
            step_in  = '0;
            phase_in = P_ROOT;
         end
         P_ROOT: begin
            rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
            rem_in  = take ? rem_diff[REM_W-1:0] : rem_shift[REM_W-1:0];
            root_in = {root_ff[DIST_W-2:0], take};
            step_in = step_ff + 1'b1;
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               done_in  = 1'b1;
               phase_in = P_IDLE;
            end
         end
         default: begin
            phase_in = P_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= P_IDLE;
         step_ff  <= '0;
         done_ff  <= 1'b0;
      end else begin
         phase_ff <= phase_in;
         step_ff  <= step_in;
         done_ff  <= done_in;
      end
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      prod_ff <= prod_in;
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done     = done_ff;
   assign distance = root_ff;

   a_done_pulse : assert property (@(posedge clock) disable iff (reset)
      done_ff |=> !done_ff)
      else $error("distance done held for more than one cycle");

endmodule

// ===== sv/pair_cpa_event_detector.sv =====
// Channel  | Handshake               | Payload
// ---------+-------------------------+--------------------------------------------
// request  | start in, busy out      | req_mode, req_pair_slot, req_own_x/_y,
//          |                         | req_contact_x/_y, req_both_ignored
// response | rsp_valid out (strobe)  | rsp_cpa_event ... rsp_ever_closest_valid
// csr      | csr_write_en in         | csr_index, csr_write_data
//
// An observation takes one pair-table lookup, two squarings on a shared multiplier,
// one add, 25 root digits, one a cycle, an update of the pair history and the register
// that shows the result; the root loop sets the pace.
// A skipped pair is answered after the lookup alone, an end-of-round item after a sweep
// that clears the examined flags one slot a cycle.
// After reset the pair table and examined flags are cleared one slot a cycle, busy high.
// busy falls as the result is shown, so the next item may be taken at the edge that
// takes the result; the receiver cannot stall, and each result is shown for one cycle only.
module pair_cpa_event_detector
   import pcpa_pkg::*;
#(
   parameter int PAIR_SLOTS = 64
) (
   input  logic                     clock,
   input  logic                     reset,

   input  logic                     start,
   output logic                     busy,
   input  logic                     req_mode,
   input  logic [SLOT_IN_W-1:0]     req_pair_slot,
   input  logic signed [POS_W-1:0]  req_own_x,
   input  logic signed [POS_W-1:0]  req_own_y,
   input  logic signed [POS_W-1:0]  req_contact_x,
   input  logic signed [POS_W-1:0]  req_contact_y,
   input  logic                     req_both_ignored,

   output logic                     rsp_valid,
   output logic                     rsp_cpa_event,
   output logic [DIST_W-1:0]        rsp_cpa_distance,
   output logic signed [POS_W-1:0]  rsp_mid_x,
   output logic signed [POS_W-1:0]  rsp_mid_y,
   output logic [DIST_W-1:0]        rsp_distance,
   output logic                     rsp_skipped,
   output logic [DIST_W-1:0]        rsp_round_closest,
   output logic                     rsp_round_closest_valid,
   output logic [DIST_W-1:0]        rsp_ever_closest,
   output logic                     rsp_ever_closest_valid,

   input  logic                     csr_write_en,
   input  logic [CSR_IDX_W-1:0]     csr_index,
   input  logic [DIST_W-1:0]        csr_write_data
);

   localparam int SLOT_W = $clog2(PAIR_SLOTS);
   localparam int EXT_W  = SLOT_W + SLOT_IN_W;

   // Sequencer states.
   localparam logic [2:0] ST_INIT  = 3'd0;
   localparam logic [2:0] ST_IDLE  = 3'd1;
   localparam logic [2:0] ST_LOOK  = 3'd2;
   localparam logic [2:0] ST_DIST  = 3'd3;
   localparam logic [2:0] ST_ROUND = 3'd4;

   logic [2:0]               state_ff, state_in;
   logic [SLOT_W-1:0]        sweep_ff, sweep_in;
   logic [SLOT_W-1:0]        slot_ff, slot_in;
   logic                     skip_pre_ff, skip_pre_in;
   logic signed [POS_W-1:0]  own_x_ff, own_x_in, own_y_ff, own_y_in;
   logic signed [DIFF_W-1:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [DIST_W-1:0]        ignore_ff, ignore_in, report_ff, report_in;
   logic [DIST_W-1:0]        swing_ff, swing_in;
   logic [DIST_W-1:0]        round_ff, round_in, ever_ff, ever_in;
   logic                     round_valid_ff, round_valid_in;
   logic                     ever_valid_ff, ever_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_ff, rsp_in;

   // Slot decode: the six-bit slot field is widened so that it can be compared with any
   // table depth, and slots at or above the depth are skipped.
   logic [EXT_W-1:0]         slot_ext;
   logic [SLOT_W-1:0]        slot_idx;
   logic                     slot_out;
   logic signed [DIFF_W-1:0] dx_new, dy_new;
   logic                     accept;
   logic                     sweep_last;

   // Pair table and examined flags.
   slot_type                 tbl_rd, tbl_wr;
   logic                     tbl_we;
   logic [SLOT_W-1:0]        tbl_wr_addr, rd_addr;
   logic [0:0]               exam_rd, exam_wr;
   logic                     exam_we;
   logic [SLOT_W-1:0]        exam_wr_addr;

   // Distance unit.
   logic                     dist_start, dist_done;
   logic [DIST_W-1:0]        dist_q;

   // Update of one pair's history.
   slot_type                 upd;
   logic                     upd_fire;
   logic                     cpa_hit;
   logic [DIST_W:0]          d_plus_swing, min_plus_swing;
   logic signed [DIFF_W-1:0] half_dx, half_dy;
   logic signed [DIFF_W-1:0] mid_x_full, mid_y_full;

   assign slot_ext   = {SLOT_W'(0), req_pair_slot};
   assign slot_idx   = slot_ext[SLOT_W-1:0];
   assign slot_out   = slot_ext >= EXT_W'(PAIR_SLOTS);
   assign dx_new     = req_contact_x - req_own_x;
   assign dy_new     = req_contact_y - req_own_y;
   assign accept     = start && (state_ff == ST_IDLE);
   assign sweep_last = sweep_ff == SLOT_W'(PAIR_SLOTS - 1);

   assign rd_addr = (state_ff == ST_IDLE) ? slot_idx : slot_ff;

   pcpa_ram #(
      .WIDTH ($bits(slot_type)),
      .DEPTH (PAIR_SLOTS)
   ) u_pair_tbl (
      .clock   (clock),
      .wr_en   (tbl_we),
      .wr_addr (tbl_wr_addr),
      .wr_data (tbl_wr),
      .rd_addr (rd_addr),
      .rd_data (tbl_rd)
   );

   pcpa_ram #(
      .WIDTH (1),
      .DEPTH (PAIR_SLOTS)
   ) u_exam_tbl (
      .clock   (clock),
      .wr_en   (exam_we),
      .wr_addr (exam_wr_addr),
      .wr_data (exam_wr),
      .rd_addr (rd_addr),
      .rd_data (exam_rd)
   );

   assign dist_start = (state_ff == ST_LOOK) && !(skip_pre_ff || exam_rd[0]);

   pcpa_dist u_dist (
      .clock    (clock),
      .reset    (reset),
      .start    (dist_start),
      .dx       (dx_ff),
      .dy       (dy_ff),
      .done     (dist_done),
      .distance (dist_q)
   );

   // Midpoint is the own position plus half the offset, rounded towards minus infinity.
   assign half_dx    = dx_ff >>> 1;
   assign half_dy    = dy_ff >>> 1;
   assign mid_x_full = own_x_ff + half_dx;
   assign mid_y_full = own_y_ff + half_dy;

   assign upd_fire       = (state_ff == ST_DIST) && dist_done;
   assign d_plus_swing   = {1'b0, dist_q} + {1'b0, swing_ff};
   assign min_plus_swing = {1'b0, tbl_rd.run_min} + {1'b0, swing_ff};

   // Hysteresis update. A pair beyond the ignore range loses its history; a fresh pair
   // only records its distance; otherwise a fall may set closing once the range has
   // dropped by more than the swing below the running maximum, and a rise may clear it
   // once the range has climbed by more than the swing above the running minimum.
   // An unchanged distance leaves everything as it was.
   always_comb begin
      upd = tbl_rd;
      priority if (dist_q > ignore_ff) begin
         upd.has_dist = 1'b0;
         upd.closing  = 1'b0;
         upd.valid    = 1'b0;
      end else if (!tbl_rd.has_dist) begin
         upd.has_dist = 1'b1;
         upd.last     = dist_q;
         upd.closing  = 1'b0;
         upd.valid    = 1'b0;
      end else if (tbl_rd.last != dist_q) begin
         if (tbl_rd.last > dist_q) begin
            if (!tbl_rd.closing && ({1'b0, tbl_rd.run_max} > d_plus_swing)) begin
               upd.closing = 1'b1;
            end
            upd.run_min = dist_q;
         end else begin
            if (tbl_rd.closing && ({1'b0, dist_q} > min_plus_swing)) begin
               upd.closing = 1'b0;
            end
            upd.run_max = dist_q;
         end
         upd.last  = dist_q;
         upd.valid = 1'b1;
      end else begin
         upd = tbl_rd;
      end
   end

   // A closest point of approach is passed when a pair that was valid and closing turns
   // to opening while still valid, and its running minimum is within the report range.
   assign cpa_hit = tbl_rd.valid && upd.valid && tbl_rd.closing && !upd.closing
                    && (upd.run_min <= report_ff);

   // Table writes: the reset sweep clears both tables, the end-of-round sweep clears the
   // examined flags, and an observed pair writes its new history and marks itself.
   always_comb begin
      tbl_we       = 1'b0;
      tbl_wr_addr  = slot_ff;
      tbl_wr       = upd;
      exam_we      = 1'b0;
      exam_wr_addr = slot_ff;
      exam_wr      = 1'b0;
      if (state_ff == ST_INIT) begin
         tbl_we       = 1'b1;
         tbl_wr_addr  = sweep_ff;
         tbl_wr       = '0;
         exam_we      = 1'b1;
         exam_wr_addr = sweep_ff;
      end else if (state_ff == ST_ROUND) begin
         exam_we      = 1'b1;
         exam_wr_addr = sweep_ff;
      end else if (upd_fire) begin
         tbl_we  = 1'b1;
         exam_we = 1'b1;
         exam_wr = 1'b1;
      end
   end

   // Configuration writes keep the report range at or below the ignore range.
   always_comb begin
      ignore_in = ignore_ff;
      report_in = report_ff;
      swing_in  = swing_ff;
      if (csr_write_en) begin
         unique case (csr_index)
            CSR_IGNORE: begin
               ignore_in = csr_write_data;
               if (report_ff > csr_write_data) begin
                  report_in = csr_write_data;
               end
            end
            CSR_REPORT: begin
               report_in = csr_write_data;
               if (ignore_ff < csr_write_data) begin
                  ignore_in = csr_write_data;
               end
            end
            CSR_SWING: begin
               swing_in = csr_write_data;
            end
            default: begin
               swing_in = swing_ff;
            end
         endcase
      end
   end

   // Sequencer.
   always_comb begin
      state_in       = state_ff;
      sweep_in       = sweep_ff;
      slot_in        = slot_ff;
      skip_pre_in    = skip_pre_ff;
      own_x_in       = own_x_ff;
      own_y_in       = own_y_ff;
      dx_in          = dx_ff;
      dy_in          = dy_ff;
      round_in       = round_ff;
      round_valid_in = round_valid_ff;
      ever_in        = ever_ff;
      ever_valid_in  = ever_valid_ff;
      rsp_valid_in   = 1'b0;
      rsp_in         = rsp_ff;
      unique case (state_ff)
         ST_INIT: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (accept) begin
               slot_in     = slot_idx;
               skip_pre_in = slot_out || req_both_ignored;
               own_x_in    = req_own_x;
               own_y_in    = req_own_y;
               dx_in       = dx_new;
               dy_in       = dy_new;
               if (req_mode) begin
                  round_in       = '0;
                  round_valid_in = 1'b0;
                  sweep_in       = '0;
                  state_in       = ST_ROUND;
               end else begin
                  state_in = ST_LOOK;
               end
            end
         end
         ST_LOOK: begin
            if (skip_pre_ff || exam_rd[0]) begin
               rsp_valid_in   = 1'b1;
               rsp_in         = '0;
               rsp_in.skipped = 1'b1;
               state_in       = ST_IDLE;
            end else begin
               state_in = ST_DIST;
            end
         end
         ST_DIST: begin
            if (dist_done) begin
               if (!round_valid_ff || (dist_q < round_ff)) begin
                  round_in       = dist_q;
                  round_valid_in = 1'b1;
               end
               if (!ever_valid_ff || (dist_q < ever_ff)) begin
                  ever_in       = dist_q;
                  ever_valid_in = 1'b1;
               end
               rsp_valid_in        = 1'b1;
               rsp_in.cpa_event    = cpa_hit;
               rsp_in.cpa_distance = cpa_hit ? upd.run_min : '0;
               rsp_in.mid_x        = mid_x_full[POS_W-1:0];
               rsp_in.mid_y        = mid_y_full[POS_W-1:0];
               rsp_in.distance     = dist_q;
               rsp_in.skipped      = 1'b0;
               state_in            = ST_IDLE;
            end
         end
         ST_ROUND: begin
            sweep_in = sweep_ff + 1'b1;
            if (sweep_last) begin
               rsp_valid_in = 1'b1;
               rsp_in       = '0;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_INIT;
         sweep_ff       <= '0;
         ignore_ff      <= IGNORE_RESET;
         report_ff      <= REPORT_RESET;
         swing_ff       <= SWING_RESET;
         round_ff       <= '0;
         round_valid_ff <= 1'b0;
         ever_ff        <= '0;
         ever_valid_ff  <= 1'b0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         state_ff       <= state_in;
         sweep_ff       <= sweep_in;
         ignore_ff      <= ignore_in;
         report_ff      <= report_in;
         swing_ff       <= swing_in;
         round_ff       <= round_in;
         round_valid_ff <= round_valid_in;
         ever_ff        <= ever_in;
         ever_valid_ff  <= ever_valid_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
      slot_ff     <= slot_in;
      skip_pre_ff <= skip_pre_in;
      own_x_ff    <= own_x_in;
      own_y_ff    <= own_y_in;
      dx_ff       <= dx_in;
      dy_ff       <= dy_in;
      rsp_ff      <= rsp_in;
   end

   assign busy                    = state_ff != ST_IDLE;
   assign rsp_valid               = rsp_valid_ff;
   assign rsp_cpa_event           = rsp_ff.cpa_event;
   assign rsp_cpa_distance        = rsp_ff.cpa_distance;
   assign rsp_mid_x               = rsp_ff.mid_x;
   assign rsp_mid_y               = rsp_ff.mid_y;
   assign rsp_distance            = rsp_ff.distance;
   assign rsp_skipped             = rsp_ff.skipped;
   assign rsp_round_closest       = round_ff;
   assign rsp_round_closest_valid = round_valid_ff;
   assign rsp_ever_closest        = ever_ff;
   assign rsp_ever_closest_valid  = ever_valid_ff;

   a_rsp_single : assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |=> !rsp_valid_ff)
      else $error("results shown in two consecutive cycles");

   a_range_order : assert property (@(posedge clock) disable iff (reset)
      report_ff <= ignore_ff)
      else $error("report range above ignore range");

   a_cpa_opening : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.cpa_event) |-> (!rsp_ff.skipped
                                              && (rsp_ff.distance > rsp_ff.cpa_distance)))
      else $error("event reported on a pair that is not opening");

   a_closest_order : assert property (@(posedge clock) disable iff (reset)
      round_valid_ff |-> (ever_valid_ff && (ever_ff <= round_ff)))
      else $error("closest since reset above closest of the round");

endmodule

// ===== tb/pair_cpa_event_detector_test.sv =====
`timescale 1ns / 100ps

module pair_cpa_event_detector_test;
   import pcpa_pkg::*;

   // The block is built with its default table of 64 pair slots.
   localparam int SLOTS = 64;

   // Half period of the clock, and the bound on the whole run in clock
   // cycles. The slowest correct run stays well within it: every
   // end-of-round item sweeps the table and every observation that is not
   // skipped runs the root loop, plus the sender's gaps.
   localparam int HALF_PERIOD  = 4;
   localparam int LIMIT_CYCLES = 400_000;

   // Quiet cycles before a register write, and at the very end. An
   // end-of-round item is the longest piece of work.
   localparam int SETTLE_CYCLES = 8;
   localparam int DRAIN_CYCLES  = 2 * (SLOTS + 1);

   localparam int POS_MIN = -8388608;
   localparam int POS_MAX = 8388607;
   // Positions on a track keep within this distance of the origin, so that
   // the offset to the contact never wraps.
   localparam int SPAN = 7_900_000;

   localparam logic [CSR_IDX_W-1:0] CSR_UNUSED = 2'd3;
   localparam logic [DIST_W-1:0]    RANGE_MAX  = '1;

   // Number of vehicle pairs followed at once by the random stimulus.
   localparam int TRACKS = 6;

   typedef enum logic {
      MODE_OBSERVE   = 1'b0,
      MODE_ROUND_END = 1'b1
   } req_mode_type;

   // One item as it is put on the request ports.
   typedef struct {
      req_mode_type            mode;
      logic [SLOT_IN_W-1:0]    slot;
      logic signed [POS_W-1:0] ox;
      logic signed [POS_W-1:0] oy;
      logic signed [POS_W-1:0] cx;
      logic signed [POS_W-1:0] cy;
      logic                    ignored;
   } pair_obs_type;

   // The full result of one item: the per-pair part, then the closest ranges.
   typedef struct packed {
      rsp_type           pair;
      logic [DIST_W-1:0] round_min;
      logic              round_seen;
      logic [DIST_W-1:0] ever_min;
      logic              ever_seen;
   } cpa_outcome_type;

   logic clock;
   logic reset = 1'b1;

   logic                    start            = 1'b0;
   logic                    busy;
   logic                    req_mode         = 1'b0;
   logic [SLOT_IN_W-1:0]    req_pair_slot    = '0;
   logic signed [POS_W-1:0] req_own_x        = '0;
   logic signed [POS_W-1:0] req_own_y        = '0;
   logic signed [POS_W-1:0] req_contact_x    = '0;
   logic signed [POS_W-1:0] req_contact_y    = '0;
   logic                    req_both_ignored = 1'b0;

   logic                    rsp_valid;
   logic                    rsp_cpa_event;
   logic [DIST_W-1:0]       rsp_cpa_distance;
   logic signed [POS_W-1:0] rsp_mid_x;
   logic signed [POS_W-1:0] rsp_mid_y;
   logic [DIST_W-1:0]       rsp_distance;
   logic                    rsp_skipped;
   logic [DIST_W-1:0]       rsp_round_closest;
   logic                    rsp_round_closest_valid;
   logic [DIST_W-1:0]       rsp_ever_closest;
   logic                    rsp_ever_closest_valid;

   logic                    csr_write_en   = 1'b0;
   logic [CSR_IDX_W-1:0]    csr_index      = '0;
   logic [DIST_W-1:0]       csr_write_data = '0;

   pair_cpa_event_detector #(
      .PAIR_SLOTS (SLOTS)
   ) dut (
      .clock                   (clock),
      .reset                   (reset),
      .start                   (start),
      .busy                    (busy),
      .req_mode                (req_mode),
      .req_pair_slot           (req_pair_slot),
      .req_own_x               (req_own_x),
      .req_own_y               (req_own_y),
      .req_contact_x           (req_contact_x),
      .req_contact_y           (req_contact_y),
      .req_both_ignored        (req_both_ignored),
      .rsp_valid               (rsp_valid),
      .rsp_cpa_event           (rsp_cpa_event),
      .rsp_cpa_distance        (rsp_cpa_distance),
      .rsp_mid_x               (rsp_mid_x),
      .rsp_mid_y               (rsp_mid_y),
      .rsp_distance            (rsp_distance),
      .rsp_skipped             (rsp_skipped),
      .rsp_round_closest       (rsp_round_closest),
      .rsp_round_closest_valid (rsp_round_closest_valid),
      .rsp_ever_closest        (rsp_ever_closest),
      .rsp_ever_closest_valid  (rsp_ever_closest_valid),
      .csr_write_en            (csr_write_en),
      .csr_index               (csr_index),
      .csr_write_data          (csr_write_data)
   );

   // Items waiting to be sent, and the results still owed by the block, oldest
   // first.
   pair_obs_type    sightings_due [$];
   cpa_outcome_type results_due [$];
   pair_obs_type    on_port;

   int gap_pct        = 17;
   int mismatch_count = 0;

   // Our own copy of the registers and of the range history of every pair.
   // The history is all zero after reset, which the bit types give for free.
   bit [DIST_W-1:0] ignore_lim = IGNORE_RESET;
   bit [DIST_W-1:0] report_lim = REPORT_RESET;
   bit [DIST_W-1:0] swing_lim  = SWING_RESET;

   bit [DIST_W-1:0] last_dist [SLOTS];
   bit [DIST_W-1:0] run_min [SLOTS];
   bit [DIST_W-1:0] run_max [SLOTS];
   bit              has_dist [SLOTS];
   bit              closing [SLOTS];
   bit              valid [SLOTS];
   bit              examined [SLOTS];
   bit [DIST_W-1:0] round_min;
   bit [DIST_W-1:0] ever_min;
   bit              round_seen;
   bit              ever_seen;

   // State of the vehicle pairs followed by the random stimulus. Each one
   // passes its contact on a straight line: the across-track miss distance is
   // fixed and the along-track offset grows by the speed at every observation.
   int trk_slot [TRACKS];
   int trk_miss [TRACKS];
   int trk_speed [TRACKS];
   int trk_t [TRACKS];
   int trk_end [TRACKS];
   bit trk_swap [TRACKS];
   bit trk_flip_x [TRACKS];
   bit trk_flip_y [TRACKS];

   initial begin
      clock = 1'b0;
      forever #HALF_PERIOD clock = ~clock;
   end

   // Floored square root, settled one bit a step from the top.
   function automatic logic [DIST_W-1:0] floor_root(input longint unsigned n);
      longint unsigned root;
      longint unsigned trial;
      root = 0;
      for (int b = DIST_W - 1; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= n) root = trial;
      end
      return root[DIST_W-1:0];
   endfunction

   // Works out the result of one item and moves our copy of the state on.
   function automatic cpa_outcome_type track_pair(input pair_obs_type it);
      cpa_outcome_type          o;
      logic signed [DIFF_W-1:0] dx;
      logic signed [DIFF_W-1:0] dy;
      logic [DIST_W-1:0]        d;
      longint unsigned          radicand;
      bit                       was_closing;
      bit                       was_valid;
      int                       s;
      o = '0;
      s = int'(it.slot);
      if (it.mode == MODE_ROUND_END) begin
         foreach (examined[i]) examined[i] = 1'b0;
         round_seen = 1'b0;
         round_min  = '0;
      end else if (s >= SLOTS || it.ignored || examined[s]) begin
         // A slot out of range or an ignored pair is tested first, but every
         // reason gives the same answer and leaves the table alone.
         o.pair.skipped = 1'b1;
      end else begin
         dx = it.cx - it.ox;
         dy = it.cy - it.oy;
         o.pair.mid_x = POS_W'(it.ox + (dx >>> 1));
         o.pair.mid_y = POS_W'(it.oy + (dy >>> 1));
         radicand = longint'(dx) * longint'(dx) + longint'(dy) * longint'(dy);
         d = floor_root(radicand);
         o.pair.distance = d;

         if (!round_seen || d < round_min) begin
            round_min  = d;
            round_seen = 1'b1;
         end
         if (!ever_seen || d < ever_min) begin
            ever_min  = d;
            ever_seen = 1'b1;
         end
         examined[s] = 1'b1;

         was_closing = closing[s];
         was_valid   = valid[s];
         if (d > ignore_lim) begin
            // Too far: the history is dropped but the extremes survive.
            has_dist[s] = 1'b0;
            closing[s]  = 1'b0;
            valid[s]    = 1'b0;
         end else if (!has_dist[s]) begin
            has_dist[s]  = 1'b1;
            last_dist[s] = d;
            closing[s]   = 1'b0;
            valid[s]     = 1'b0;
         end else if (last_dist[s] != d) begin
            // Hysteresis: the state flips only once the range has moved
            // further than the swing from the opposite extreme.
            if (d < last_dist[s]) begin
               if (!was_closing &&
                   longint'(run_max[s]) - longint'(d) > longint'(swing_lim))
                  closing[s] = 1'b1;
               run_min[s] = d;
            end else begin
               if (was_closing &&
                   longint'(d) - longint'(run_min[s]) > longint'(swing_lim))
                  closing[s] = 1'b0;
               run_max[s] = d;
            end
            last_dist[s] = d;
            valid[s]     = 1'b1;
         end

         if (was_valid && valid[s] && was_closing && !closing[s] &&
             run_min[s] <= report_lim) begin
            o.pair.cpa_event    = 1'b1;
            o.pair.cpa_distance = run_min[s];
         end
      end
      o.round_min  = round_min;
      o.round_seen = round_seen;
      o.ever_min   = ever_min;
      o.ever_seen  = ever_seen;
      return o;
   endfunction

   function automatic void check_field(input string name, input logic signed [31:0] want,
                                       input logic signed [31:0] got);
      if (got !== want) begin
         $error("%s: expected %0d, got %0d", name, want, got);
         mismatch_count++;
      end
   endfunction

   // Sender. An item stays on the ports with start high until an edge finds
   // busy low; its result is predicted at that same edge. Between items the
   // sender holds off at random, gap_pct cycles in a hundred.
   always @(posedge clock) begin : sender
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) results_due = {results_due, track_pair(on_port)};
         if (!(start && busy)) begin
            if (sightings_due.size() != 0 && $urandom_range(99) >= gap_pct) begin
               on_port = sightings_due.pop_front();
               start            <= 1'b1;
               req_mode         <= on_port.mode;
               req_pair_slot    <= on_port.slot;
               req_own_x        <= on_port.ox;
               req_own_y        <= on_port.oy;
               req_contact_x    <= on_port.cx;
               req_contact_y    <= on_port.cy;
               req_both_ignored <= on_port.ignored;
            end else begin
               start <= 1'b0;
            end
         end
      end
   end

   // Receiver. A result is shown for one cycle only, so it is taken at every
   // edge that sees the strobe and held against the oldest prediction.
   always @(posedge clock) begin : receiver
      cpa_outcome_type want;
      if (!reset && rsp_valid) begin
         if (results_due.size() == 0) begin
            $error("result with no item outstanding");
            mismatch_count++;
         end else begin
            want = results_due.pop_front();
            check_field("cpa_event", 32'(want.pair.cpa_event), 32'(rsp_cpa_event));
            check_field("cpa_distance", 32'(want.pair.cpa_distance),
                        32'(rsp_cpa_distance));
            check_field("mid_x", 32'($signed(want.pair.mid_x)), 32'(rsp_mid_x));
            check_field("mid_y", 32'($signed(want.pair.mid_y)), 32'(rsp_mid_y));
            check_field("distance", 32'(want.pair.distance), 32'(rsp_distance));
            check_field("skipped", 32'(want.pair.skipped), 32'(rsp_skipped));
            check_field("round_closest", 32'(want.round_min), 32'(rsp_round_closest));
            check_field("round_closest_valid", 32'(want.round_seen),
                        32'(rsp_round_closest_valid));
            check_field("ever_closest", 32'(want.ever_min), 32'(rsp_ever_closest));
            check_field("ever_closest_valid", 32'(want.ever_seen),
                        32'(rsp_ever_closest_valid));
         end
      end
   end

   initial begin : watchdog
      int cycles;
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("** pair_cpa_event_detector: FAILED **");
      $finish;
   end

   task automatic push_obs(input int slot, input int ox, input int oy, input int cx,
                           input int cy, input bit ignored);
      pair_obs_type it;
      it.mode    = MODE_OBSERVE;
      it.slot    = SLOT_IN_W'(slot);
      it.ox      = POS_W'(ox);
      it.oy      = POS_W'(oy);
      it.cx      = POS_W'(cx);
      it.cy      = POS_W'(cy);
      it.ignored = ignored;
      sightings_due = {sightings_due, it};
   endtask

   // The block ignores every other field of an end-of-round item, so they
   // carry random values.
   task automatic push_round_end();
      pair_obs_type it;
      it.mode    = MODE_ROUND_END;
      it.slot    = SLOT_IN_W'($urandom);
      it.ox      = POS_W'($urandom);
      it.oy      = POS_W'($urandom);
      it.cx      = POS_W'($urandom);
      it.cy      = POS_W'($urandom);
      it.ignored = 1'($urandom);
      sightings_due = {sightings_due, it};
   endtask

   // Writes one register. The block is idle whenever this is called, so our
   // copy of the registers may change at once.
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [DIST_W-1:0] val);
      @(posedge clock);
      csr_write_en   <= 1'b1;
      csr_index      <= idx;
      csr_write_data <= val;
      if (idx == CSR_IGNORE) begin
         ignore_lim = val;
         if (report_lim > ignore_lim) report_lim = ignore_lim;
      end else if (idx == CSR_REPORT) begin
         report_lim = val;
         if (ignore_lim < report_lim) ignore_lim = report_lim;
      end else if (idx == CSR_SWING) begin
         swing_lim = val;
      end
      @(posedge clock);
      csr_write_en <= 1'b0;
   endtask

   // Waits until every item has been taken and answered, then a little more.
   // The check is made at the falling edge, after everything the sender did
   // at the rising edge has settled.
   task automatic wait_quiet();
      do @(negedge clock);
      while (sightings_due.size() != 0 || start || results_due.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // Starts a new pass for one track. Most passes reuse the slot, so that the
   // extremes of the earlier pass let the closing state set on the way in.
   function automatic void new_track(input int k, input int shift);
      if ($urandom_range(99) < 25) trk_slot[k] = $urandom_range(SLOTS - 1);
      trk_miss[k]   = $urandom_range(1400) << shift;
      trk_speed[k]  = $urandom_range(120, 4) << shift;
      trk_end[k]    = $urandom_range(14, 4);
      trk_t[k]      = -trk_end[k];
      trk_swap[k]   = 1'($urandom);
      trk_flip_x[k] = 1'($urandom);
      trk_flip_y[k] = 1'($urandom);
   endfunction

   // Queues rounds of observations of the followed pairs until the budget of
   // items is spent. A few items are noise: random slots and positions,
   // ignored pairs, second looks at a pair within one round, and now and then
   // a round that is never closed.
   task automatic run_rounds(input int budget, input int shift);
      int          queued;
      int          lead;
      int          k;
      int          along;
      int          dx;
      int          dy;
      int          ox;
      int          oy;
      int unsigned roll;
      queued = 0;
      for (int n = 0; n < TRACKS; n++) begin
         trk_slot[n] = $urandom_range(SLOTS - 1);
         new_track(n, shift);
      end
      while (queued < budget) begin
         lead = $urandom_range(TRACKS - 1);
         for (int n = 0; n < TRACKS; n++) begin
            k    = (lead + n) % TRACKS;
            roll = $urandom_range(99);
            ox   = $urandom_range(2 * SPAN);
            oy   = $urandom_range(2 * SPAN);
            ox  -= SPAN;
            oy  -= SPAN;
            if (roll < 4) begin
               push_obs($urandom_range(SLOTS - 1), $urandom, $urandom, $urandom, $urandom,
                        1'($urandom));
            end else if (roll < 8) begin
               dx  = $urandom_range(4000);
               dy  = $urandom_range(4000);
               dx -= 2000;
               dy -= 2000;
               push_obs($urandom_range(SLOTS - 1), ox, oy, ox + dx, oy + dy, roll == 7);
            end else begin
               along = trk_speed[k] * trk_t[k];
               dx = trk_swap[k] ? trk_miss[k] : along;
               dy = trk_swap[k] ? along : trk_miss[k];
               if (trk_flip_x[k]) dx = -dx;
               if (trk_flip_y[k]) dy = -dy;
               push_obs(trk_slot[k], ox, oy, ox + dx, oy + dy, 1'b0);
               queued++;
               if (roll >= 93) push_obs(trk_slot[k], oy, ox, oy + dy, ox + dx, roll[0]);
               trk_t[k]++;
               if (trk_t[k] > trk_end[k]) new_track(k, shift);
            end
         end
         if ($urandom_range(99) < 94) begin
            push_round_end();
            queued++;
         end
      end
   endtask

   initial begin : stimulus
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Directed items under the reset values of the registers. Slot 0 goes
      // out to 1000, 1100, then in to 900 and 700, back out by less than the
      // swing to 710, and out again to 760, which passes a reportable CPA at
      // 700; one more look at 760 leaves everything as it was.
      push_obs(0, 100, -200, 1100, -200, 1'b0);
      push_obs(0, 5, 5, 7, 7, 1'b0);                  // already examined
      push_obs(1, 0, 0, 10, 10, 1'b1);                // ignored pair
      push_obs(63, POS_MIN, POS_MIN, POS_MAX, POS_MAX, 1'b0);  // far beyond ignore range
      push_obs(2, POS_MAX, POS_MIN, POS_MIN, POS_MAX, 1'b0);
      push_obs(3, 5, -7, 5, -7, 1'b0);                // zero distance
      push_obs(4, 0, 0, -3, -5, 1'b0);                // midpoint rounds down
      push_round_end();
      push_obs(0, -5000, 3000, -5000, 4100, 1'b0);
      push_obs(1, 0, 0, 30, 40, 1'b1);
      push_round_end();
      push_obs(0, 7, 7, 907, 7, 1'b0);
      push_round_end();
      push_obs(0, 0, 0, 420, 560, 1'b0);
      push_round_end();
      push_obs(0, -1, -1, -1, 709, 1'b0);
      push_round_end();
      push_obs(0, 0, 0, -760, 0, 1'b0);
      push_round_end();
      push_obs(0, 1000, 1000, 1000, 240, 1'b0);
      push_round_end();

      run_rounds(150, 0);

      // The stimulus waits for every result before the registers change. The
      // widest ranges and no swing at all, with long passes and no gaps.
      wait_quiet();
      write_reg(CSR_IGNORE, RANGE_MAX);
      write_reg(CSR_REPORT, RANGE_MAX);
      write_reg(CSR_SWING, '0);
      gap_pct = 0;
      run_rounds(150, 8);

      // An ignore range of zero, so every pair at a nonzero distance is dropped, and the widest swing.
      wait_quiet();
      gap_pct = 17;
      write_reg(CSR_IGNORE, '0);
      write_reg(CSR_SWING, RANGE_MAX);
      run_rounds(40, 0);

      // A report range above the ignore range drags the ignore range up.
      wait_quiet();
      write_reg(CSR_REPORT, 25'd2400);
      write_reg(CSR_SWING, 25'd1);
      write_reg(CSR_UNUSED, DIST_W'($urandom));
      run_rounds(130, 1);

      wait_quiet();
      write_reg(CSR_SWING, DIST_W'($urandom_range(64)));
      write_reg(CSR_IGNORE, DIST_W'($urandom_range(3000, 400)));
      write_reg(CSR_REPORT, DIST_W'($urandom_range(3200)));
      run_rounds(130, 0);

      wait_quiet();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && results_due.size() == 0) begin
         $display("** pair_cpa_event_detector: PASSED **");
      end else begin
         $display("** pair_cpa_event_detector: FAILED **");
      end
      $finish;
   end

endmodule

// ===== pair_cpa_event_detector.f =====
sv/pcpa_pkg.sv
sv/pcpa_ram.sv
sv/pcpa_dist.sv
sv/pair_cpa_event_detector.sv
tb/pair_cpa_event_detector_test.sv
